### rtl/core/rbet_pkg.sv
`timescale 1ns / 1ps

package rbet_pkg;

	// Quotient bits produced by the divider; larger ray parameters clip.
	localparam int Q_BITS = 31;
	// Pipeline positions after the input register.
	localparam int P_MUL = Q_BITS + 1;
	localparam int P_PT  = Q_BITS + 2;
	localparam int P_END = Q_BITS + 3;

	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	typedef enum logic [2:0] {
		FACE_NONE  = 3'd0,
		FACE_MAX_X = 3'd1,
		FACE_MIN_X = 3'd2,
		FACE_MAX_Y = 3'd3,
		FACE_MIN_Y = 3'd4,
		FACE_MAX_Z = 3'd5,
		FACE_MIN_Z = 3'd6
	} face_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
	} ray_t;

	typedef struct packed {
		logic               hit;
		logic               origin_inside;
		logic [2:0]         hit_face;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic               saturated;
	} res_t;

	// Result of one axis lane; pt[0] is x.
	typedef struct packed {
		logic             ok;
		logic             sat;
		logic [2:0]       face;
		logic [2:0][31:0] pt;
	} lane_res_t;

	function automatic logic signed [31:0] org_of(input ray_t r, input int unsigned a);
		case (a)
			0: org_of = r.origin_x;
			1: org_of = r.origin_y;
			default: org_of = r.origin_z;
		endcase
	endfunction

	function automatic logic signed [31:0] dir_of(input ray_t r, input int unsigned a);
		case (a)
			0: dir_of = r.dir_x;
			1: dir_of = r.dir_y;
			default: dir_of = r.dir_z;
		endcase
	endfunction

	function automatic logic signed [31:0] lo_of(input ray_t r, input int unsigned a);
		case (a)
			0: lo_of = r.box_min_x;
			1: lo_of = r.box_min_y;
			default: lo_of = r.box_min_z;
		endcase
	endfunction

	function automatic logic signed [31:0] hi_of(input ray_t r, input int unsigned a);
		case (a)
			0: hi_of = r.box_max_x;
			1: hi_of = r.box_max_y;
			default: hi_of = r.box_max_z;
		endcase
	endfunction

	function automatic logic in_span(input logic signed [31:0] v, input logic signed [31:0] lo,
			input logic signed [31:0] hi);
		in_span = (v >= lo) && (v <= hi);
	endfunction

endpackage

### rtl/core/rbet_lane.sv
`timescale 1ns / 1ps

module rbet_lane #(
	parameter int AXIS      = 0,
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              en,
	input  rbet_pkg::ray_t    ray_p0,
	input  rbet_pkg::ray_t    ray_p32,
	input  rbet_pkg::ray_t    ray_p33,
	output rbet_pkg::lane_res_t lres_s34
);
	import rbet_pkg::*;

	localparam int AB = (AXIS + 1) % 3;
	localparam int AC = (AXIS + 2) % 3;
	localparam int NW = 32 + FRAC_BITS;
	localparam int CW = 64;
	localparam logic signed [63:0] RND = (64'sd1 <<< FRAC_BITS) - 64'sd1;

	function automatic logic signed [63:0] coord(input logic signed [63:0] prod,
			input logic signed [31:0] org);
		logic signed [63:0] q;
		// Division by 2^FRAC_BITS truncated toward zero.
		q = prod[63] ? ((prod + RND) >>> FRAC_BITS) : (prod >>> FRAC_BITS);
		coord = q + 64'(org);
	endfunction

	// Front: entry face, numerator and divisor magnitudes.
	logic signed [31:0] d_a, o_a, f_a;
	logic               neg;
	logic signed [32:0] num;
	logic [32:0]        num_mag;
	logic [31:0]        d_mag;
	logic [NW-1:0]      n_wide;
	logic               pos, ovf;

	always_comb begin
		d_a     = dir_of(ray_p0, AXIS);
		o_a     = org_of(ray_p0, AXIS);
		neg     = d_a[31];
		f_a     = neg ? hi_of(ray_p0, AXIS) : lo_of(ray_p0, AXIS);
		num     = 33'(f_a) - 33'(o_a);
		num_mag = num[32] ? 33'(-num) : 33'(num);
		d_mag   = neg ? (~d_a + 32'd1) : d_a;
		n_wide  = {num_mag[31:0], {FRAC_BITS{1'b0}}};
		pos     = (d_a != 32'sd0) && (num != 33'sd0) && (num[32] == neg);
		ovf     = {{(CW-NW){1'b0}}, n_wide} >= ({32'd0, d_mag} << Q_BITS);
	end

	logic [NW-1:0]     rem_s [0:Q_BITS];
	logic [31:0]       den_s [0:Q_BITS];
	logic [Q_BITS-1:0] quo_s [0:Q_BITS];
	logic              pos_s [0:Q_BITS];
	logic              ovf_s [0:Q_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= n_wide;
			den_s[0] <= d_mag;
			quo_s[0] <= '0;
			pos_s[0] <= pos;
			ovf_s[0] <= ovf;
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar k = 1; k <= Q_BITS; k++) begin : g_div
		logic [CW-1:0] sh, ext, diff;
		logic          ge;
		always_comb begin
			sh   = {32'd0, den_s[k-1]} << (Q_BITS - k);
			ext  = {{(CW-NW){1'b0}}, rem_s[k-1]};
			ge   = ext >= sh;
			diff = ext - sh;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[NW-1:0] : rem_s[k-1];
				den_s[k] <= den_s[k-1];
				quo_s[k] <= quo_s[k-1] | (ge ? (Q_BITS'(1) << (Q_BITS - k)) : '0);
				pos_s[k] <= pos_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	// Clip t and form the products for the other two axes.
	logic [Q_BITS-1:0]  t;
	logic signed [63:0] prod_b_s33, prod_c_s33;
	logic               tpos_s33, tsat_s33;

	assign t = ovf_s[Q_BITS] ? {Q_BITS{1'b1}} : quo_s[Q_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_b_s33 <= dir_of(ray_p32, AB) * $signed({1'b0, t});
			prod_c_s33 <= dir_of(ray_p32, AC) * $signed({1'b0, t});
			tpos_s33   <= pos_s[Q_BITS] && (t != '0);
			tsat_s33   <= ovf_s[Q_BITS];
		end
	end

	logic signed [63:0] sum_b, sum_c;
	logic signed [31:0] cand_b, cand_c, f_p;
	logic               sat_b, sat_c;
	lane_res_t          lres;

	always_comb begin
		sum_b  = coord(prod_b_s33, org_of(ray_p33, AB));
		sum_c  = coord(prod_c_s33, org_of(ray_p33, AC));
		sat_b  = (sum_b > S32_MAX) || (sum_b < S32_MIN);
		sat_c  = (sum_c > S32_MAX) || (sum_c < S32_MIN);
		cand_b = (sum_b > S32_MAX) ? 32'sh7FFF_FFFF :
			(sum_b < S32_MIN) ? 32'sh8000_0000 : sum_b[31:0];
		cand_c = (sum_c > S32_MAX) ? 32'sh7FFF_FFFF :
			(sum_c < S32_MIN) ? 32'sh8000_0000 : sum_c[31:0];
		f_p    = dir_of(ray_p33, AXIS) < 0 ? hi_of(ray_p33, AXIS) : lo_of(ray_p33, AXIS);
		lres.ok = tpos_s33 && in_span(cand_b, lo_of(ray_p33, AB), hi_of(ray_p33, AB))
			&& in_span(cand_c, lo_of(ray_p33, AC), hi_of(ray_p33, AC));
		lres.sat       = tsat_s33 || sat_b || sat_c;
		lres.face      = 3'(2 * AXIS + ((dir_of(ray_p33, AXIS) < 0) ? 1 : 2));
		lres.pt        = '0;
		lres.pt[AXIS]  = f_p;
		lres.pt[AB]    = cand_b;
		lres.pt[AC]    = cand_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lres_s34 <= lres;
		end
	end

endmodule

### rtl/core/ray_box_entry_test.sv
`timescale 1ns / 1ps
// Channel  Valid      Stall      Payload
// ray      ray_valid  ray_stall  ray (rbet_pkg::ray_t)
// res      res_valid  res_stall  res (rbet_pkg::res_t)
//
// One ray enters per cycle unless a stalled result holds the pipeline.
// Each axis computes its entry t with a 31-stage restoring divider.
// arst_n clears only the valid bits; payload registers hold no reset.
// A stalled result freezes the whole pipeline, and ray_stall follows it.

module ray_box_entry_test #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ray_valid,
	output logic           ray_stall,
	input  rbet_pkg::ray_t ray,
	output logic           res_valid,
	input  logic           res_stall,
	output rbet_pkg::res_t res
);
	import rbet_pkg::*;

	logic      en;
	ray_t      ray_d [0:P_END];
	logic      v_d   [0:P_END];
	lane_res_t lres  [0:2];
	res_t      sel;
	logic      org_in;

	assign en        = !(res_valid && res_stall);
	assign ray_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= P_END; k++) v_d[k] <= 1'b0;
			res_valid <= 1'b0;
		end else if (en) begin
			v_d[0] <= ray_valid;
			for (int k = 1; k <= P_END; k++) v_d[k] <= v_d[k-1];
			res_valid <= v_d[P_END];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_d[0] <= ray;
			for (int k = 1; k <= P_END; k++) ray_d[k] <= ray_d[k-1];
			res <= sel;
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		rbet_lane #(.AXIS(g), .FRAC_BITS(FRAC_BITS)) u_lane (
			.clk      (clk),
			.en       (en),
			.ray_p0   (ray_d[0]),
			.ray_p32  (ray_d[P_MUL]),
			.ray_p33  (ray_d[P_PT]),
			.lres_s34 (lres[g])
		);
	end

	always_comb begin
		org_in = in_span(ray_d[P_END].origin_x, ray_d[P_END].box_min_x, ray_d[P_END].box_max_x)
			&& in_span(ray_d[P_END].origin_y, ray_d[P_END].box_min_y, ray_d[P_END].box_max_y)
			&& in_span(ray_d[P_END].origin_z, ray_d[P_END].box_min_z, ray_d[P_END].box_max_z);
		sel = '0;
		sel.hit_face = FACE_NONE;
		if (org_in) begin
			sel.hit           = 1'b1;
			sel.origin_inside = 1'b1;
			sel.point_x       = ray_d[P_END].origin_x;
			sel.point_y       = ray_d[P_END].origin_y;
			sel.point_z       = ray_d[P_END].origin_z;
		end else begin
			// Axes are scanned from z down to x; a hit on x overrides y, and y overrides z.
			for (int a = 2; a >= 0; a--) begin
				if (lres[a].ok) begin
					sel.hit       = 1'b1;
					sel.hit_face  = lres[a].face;
					sel.point_x   = lres[a].pt[0];
					sel.point_y   = lres[a].pt[1];
					sel.point_z   = lres[a].pt[2];
					sel.saturated = lres[a].sat;
				end
			end
		end
	end

endmodule

### rtl/core/rbet_checker.sv
`timescale 1ns / 1ps

module rbet_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           ray_stall,
	input logic           res_valid,
	input logic           res_stall,
	input rbet_pkg::res_t res
);
	import rbet_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	a_no_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !ray_stall)
		else $error("input stalled with no pending result");

	a_inside: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.origin_inside |-> res.hit && res.hit_face == FACE_NONE && !res.saturated)
		else $error("inside result malformed");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.hit |-> res.hit_face == FACE_NONE && res.point_x == 0
			&& res.point_y == 0 && res.point_z == 0 && !res.saturated && !res.origin_inside)
		else $error("miss result not cleared");

	a_face: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.hit && !res.origin_inside |-> res.hit_face != FACE_NONE)
		else $error("entry hit without face");

endmodule

bind ray_box_entry_test rbet_checker u_rbet_checker (.*);

### sim/ray_box_entry_test_tb.sv
`timescale 1ns / 1ps

module ray_box_entry_test_tb;
	import rbet_pkg::*;

	localparam int FRAC = 16;
	localparam int IDLE_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic ray_valid;
	logic ray_stall;
	ray_t ray;
	logic res_valid;
	logic res_stall;
	res_t res;

	res_t expected_q[$];
	int   fail_count = 0;
	int   checked = 0;
	int   hits_seen = 0;
	int   inside_seen = 0;
	int   sat_seen = 0;
	bit   allow_ray_idle = 1;
	bit   allow_res_stall = 1;
	bit   hold_res = 0;
	int   idle_cycles = 0;

	ray_box_entry_test #(.FRAC_BITS(FRAC)) u_top (
		.clk(clk), .arst_n(arst_n),
		.ray_valid(ray_valid), .ray_stall(ray_stall), .ray(ray),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic longint clip_s32(input longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic bit in_range(input longint v, input longint lo, input longint hi);
		return v >= lo && v <= hi;
	endfunction

	// SystemVerilog division of signed longints truncates toward zero, as needed.
	function automatic res_t entry_point(input ray_t r);
		res_t   o;
		longint org[3], dir[3], lo[3], hi[3], cand[3];
		longint f, num, t;
		bit     s;
		int     b, c;
		o = '0;
		org = '{r.origin_x, r.origin_y, r.origin_z};
		dir = '{r.dir_x, r.dir_y, r.dir_z};
		lo = '{r.box_min_x, r.box_min_y, r.box_min_z};
		hi = '{r.box_max_x, r.box_max_y, r.box_max_z};
		if (in_range(org[0], lo[0], hi[0]) && in_range(org[1], lo[1], hi[1]) &&
				in_range(org[2], lo[2], hi[2])) begin
			o.hit = 1;
			o.origin_inside = 1;
			o.hit_face = FACE_NONE;
			o.point_x = r.origin_x;
			o.point_y = r.origin_y;
			o.point_z = r.origin_z;
			return o;
		end
		for (int a = 0; a < 3; a++) begin
			if (dir[a] == 0) continue;
			s = 0;
			b = (a + 1) % 3;
			c = (a + 2) % 3;
			f = (dir[a] < 0) ? hi[a] : lo[a];
			num = f - org[a];
			t = clip_s32((num * (64'sd1 <<< FRAC)) / dir[a], s);
			if (t <= 0) continue;
			cand[a] = f;
			cand[b] = clip_s32(org[b] + (dir[b] * t) / (64'sd1 <<< FRAC), s);
			cand[c] = clip_s32(org[c] + (dir[c] * t) / (64'sd1 <<< FRAC), s);
			if (in_range(cand[b], lo[b], hi[b]) && in_range(cand[c], lo[c], hi[c])) begin
				o.hit = 1;
				o.hit_face = 3'(2 * a + ((dir[a] < 0) ? 1 : 2));
				o.point_x = cand[0][31:0];
				o.point_y = cand[1][31:0];
				o.point_z = cand[2][31:0];
				o.saturated = s;
				return o;
			end
		end
		return o;
	endfunction

	// Valid stays high after an accepted transaction; callers drop it when done.
	task automatic send_ray(input ray_t r);
		int gap;
		if (allow_ray_idle && $urandom_range(0, 5) == 0) begin
			ray_valid <= 0;
			gap = $urandom_range(1, 19);
			repeat (gap) @(negedge clk);
		end
		ray <= r;
		ray_valid <= 1;
		@(posedge clk);
		while (ray_stall) @(posedge clk);
		expected_q = {expected_q, entry_point(r)};
		@(negedge clk);
	endtask

	// Outputs are sampled at the rising edge; stall is driven at the falling edge.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			res_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected: %p", $time, res);
				fail_count++;
			end else begin
				e = expected_q.pop_front();
				checked++;
				if (res.hit !== e.hit || res.origin_inside !== e.origin_inside ||
						res.hit_face !== e.hit_face || res.point_x !== e.point_x ||
						res.point_y !== e.point_y || res.point_z !== e.point_z ||
						res.saturated !== e.saturated) begin
					$display("%0t: mismatch expected %p actual %p", $time, e, res);
					fail_count++;
				end
				hits_seen += e.hit;
				inside_seen += e.origin_inside;
				sat_seen += e.saturated;
			end
		end
	end

	initial begin
		int n;
		res_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_res) begin
				res_stall <= 1;
			end else if (allow_res_stall && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 19);
				res_stall <= 1;
				repeat (n) @(negedge clk);
				res_stall <= 0;
			end else begin
				res_stall <= 0;
			end
		end
	end

	always @(posedge clk) begin
		if ((ray_valid && !ray_stall) || (res_valid && !res_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("ray_box_entry_test_tb failed");
			$finish;
		end
	end

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			default: return $urandom_range(0, 32'h00140000) - 32'h000a0000;
		endcase
	endfunction

	// Box around a small region; rays mostly start outside it and mostly aim at it.
	function automatic ray_t aimed_ray();
		ray_t r;
		int   sz;
		sz = $urandom_range(1, 32'h00040000);
		r.box_min_x = $urandom_range(0, 32'h00080000) - 32'h00040000;
		r.box_min_y = $urandom_range(0, 32'h00080000) - 32'h00040000;
		r.box_min_z = $urandom_range(0, 32'h00080000) - 32'h00040000;
		r.box_max_x = r.box_min_x + sz;
		r.box_max_y = r.box_min_y + $urandom_range(0, 32'h00040000);
		r.box_max_z = r.box_min_z + $urandom_range(0, 32'h00040000);
		r.origin_x = $urandom_range(0, 32'h00200000) - 32'h00100000;
		r.origin_y = $urandom_range(0, 32'h00200000) - 32'h00100000;
		r.origin_z = $urandom_range(0, 32'h00200000) - 32'h00100000;
		r.dir_x = (r.box_min_x - r.origin_x) + $urandom_range(0, sz);
		r.dir_y = (r.box_min_y - r.origin_y) + $urandom_range(0, sz);
		r.dir_z = (r.box_min_z - r.origin_z) + $urandom_range(0, sz);
		if ($urandom_range(0, 3) == 0) r.dir_x = 0;
		if ($urandom_range(0, 3) == 0) r.dir_y = $urandom_range(0, 3) - 1;
		if ($urandom_range(0, 5) == 0) r.dir_z = $urandom() >>> $urandom_range(0, 20);
		return r;
	endfunction

	function automatic ray_t noise_ray();
		ray_t r;
		r.origin_x = rnd_coord(); r.origin_y = rnd_coord(); r.origin_z = rnd_coord();
		r.dir_x = rnd_coord(); r.dir_y = rnd_coord(); r.dir_z = rnd_coord();
		r.box_min_x = rnd_coord(); r.box_min_y = rnd_coord(); r.box_min_z = rnd_coord();
		r.box_max_x = rnd_coord(); r.box_max_y = rnd_coord(); r.box_max_z = rnd_coord();
		return r;
	endfunction

	function automatic ray_t mk(input int ox, oy, oz, dx, dy, dz,
			input int lx, ly, lz, hx, hy, hz);
		ray_t r;
		r = '{ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz};
		return r;
	endfunction

	task automatic test_directed();
		int one;
		one = 32'h10000;
		// Origin inside, on a corner, and box with all-extreme bounds.
		send_ray(mk(0, 0, 0, one, 0, 0, -one, -one, -one, one, one, one));
		send_ray(mk(one, one, one, 0, 0, 0, -one, -one, -one, one, one, one));
		send_ray(mk(0, 0, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		// Each face from outside.
		send_ray(mk(5 * one, 0, 0, -one, 0, 0, -one, -one, -one, one, one, one));
		send_ray(mk(-5 * one, 0, 0, one, 0, 0, -one, -one, -one, one, one, one));
		send_ray(mk(0, 5 * one, 0, 0, -one, 0, -one, -one, -one, one, one, one));
		send_ray(mk(0, -5 * one, 0, 0, one, 0, -one, -one, -one, one, one, one));
		send_ray(mk(0, 0, 5 * one, 0, 0, -one, -one, -one, -one, one, one, one));
		send_ray(mk(0, 0, -5 * one, 0, 0, one, -one, -one, -one, one, one, one));
		// Pointing away, zero direction, and a miss past the side.
		send_ray(mk(5 * one, 0, 0, one, 0, 0, -one, -one, -one, one, one, one));
		send_ray(mk(5 * one, 0, 0, 0, 0, 0, -one, -one, -one, one, one, one));
		send_ray(mk(5 * one, 5 * one, 0, -one, 0, 0, -one, -one, -one, one, one, one));
		// Inverted box.
		send_ray(mk(5 * one, 0, 0, -one, 0, 0, one, one, one, -one, -one, -one));
		// Tiny direction clips t; large direction on the side axis clips the point.
		send_ray(mk(32'h80000000, 0, 0, 1, 0, 0, 32'h7fff0000, -one, -one,
			32'h7fffffff, one, one));
		send_ray(mk(-5 * one, 0, 0, 1, 32'h7fffffff, 0, -one, 32'h80000000, -one,
			one, 32'h7fffffff, one));
		send_ray(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0));
		send_ray(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		send_ray(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++)
			send_ray(($urandom_range(0, 3) == 0) ? noise_ray() : aimed_ray());
	endtask

	// Receiver holds off while rays keep coming, so the pipeline fills and stalls.
	task automatic test_backpressure();
		fork
			begin
				hold_res = 1;
				repeat (120) @(negedge clk);
				hold_res = 0;
			end
			begin
				allow_ray_idle = 0;
				test_random(80);
				ray_valid <= 0;
				allow_ray_idle = 1;
			end
		join
	endtask

	task automatic test_full_rate(input int count);
		allow_ray_idle = 0;
		allow_res_stall = 0;
		test_random(count);
	endtask

	initial begin
		arst_n = 0;
		ray_valid = 0;
		ray = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_random(1300);
		test_backpressure();
		test_full_rate(450);
		ray_valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Checked %0d results: %0d hits, %0d with origin inside, %0d saturated.",
			checked, hits_seen, inside_seen, sat_seen);
		$display("Directed faces, random aimed and noise rays, backpressure and full rate.");
		if (fail_count == 0)
			$display("ray_box_entry_test_tb passed");
		else
			$display("ray_box_entry_test_tb failed");
		$finish;
	end

endmodule
